@@ sv/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Shared widths, operation codes, the control word that travels down the
// pipeline, and the operand pairing of the first multiplier bank.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int DATA_W        = 32;
    localparam int NPROD         = 16;
    localparam int NROT          = 9;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef enum logic [2:0] {
        MODE_MUL  = 3'd0,
        MODE_ROT  = 3'd1,
        MODE_MAT  = 3'd2,
        MODE_CONJ = 3'd3,
        MODE_NORM = 3'd4
    } t_mode;

    // Component indices
    localparam logic [1:0] CX = 2'd0;
    localparam logic [1:0] CY = 2'd1;
    localparam logic [1:0] CZ = 2'd2;
    localparam logic [1:0] CW = 2'd3;

    // Matrix row codes
    localparam logic [1:0] ROW_0    = 2'd0;
    localparam logic [1:0] ROW_1    = 2'd1;
    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef struct packed {
        t_mode      mode;
        logic [1:0] row;
        logic       last;
    } t_ctl;

    // Operand pairs of the first bank: A component times B component.
    // With B replaced by A the same pairs give every square and cross term.
    localparam logic [1:0] PROD_A_IDX [NPROD] = '{
        CW, CX, CY, CZ,
        CW, CY, CZ, CX,
        CW, CZ, CX, CY,
        CW, CX, CY, CZ
    };
    localparam logic [1:0] PROD_B_IDX [NPROD] = '{
        CX, CW, CZ, CY,
        CY, CW, CX, CZ,
        CZ, CW, CY, CX,
        CW, CX, CY, CZ
    };

endpackage

@@ sv/quaternion_arithmetic_unit.sv @@
// A row goes from the first stage through stages 2 to 7 into the output register.
// One item per cycle unless stalled; a matrix item holds the input for three rows.
// The matrix rows are issued by a row counter in front of the first stage.
// Reset (synchronous, active low) clears the stage valid bits and the row counter.
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Eight-stage pipeline in signed fixed point: Hamilton product, vector
// rotation, rotation matrix rows, conjugate and squared norm, each result
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input channel
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [2:0]   i_mode,
    input  logic signed [DATA_W-1:0] i_a_x,
    input  logic signed [DATA_W-1:0] i_a_y,
    input  logic signed [DATA_W-1:0] i_a_z,
    input  logic signed [DATA_W-1:0] i_a_w,
    input  logic signed [DATA_W-1:0] i_b_x,
    input  logic signed [DATA_W-1:0] i_b_y,
    input  logic signed [DATA_W-1:0] i_b_z,
    input  logic signed [DATA_W-1:0] i_b_w,
    // output channel
    output logic         o_valid,
    input  logic         i_stall,
    output logic signed [DATA_W-1:0] o_res_0,
    output logic signed [DATA_W-1:0] o_res_1,
    output logic signed [DATA_W-1:0] o_res_2,
    output logic signed [DATA_W-1:0] o_res_3,
    output logic         o_last
);

    // Widths: full product, rounded product, and the wide sum domain
    localparam int PW  = 2 * DATA_W;
    localparam int MW  = PW - FRAC_BITS;
    localparam int SW  = MW + 4;
    localparam int NST = 8;

    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] WMAX = (SW'(1) <<< (DATA_W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);

    // Round half up and drop the fraction bits of a full product
    function automatic logic signed [MW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + HALF;
        return t[PW-1:FRAC_BITS];
    endfunction

    // Saturate a wide sum to the 32-bit word
    function automatic t_word sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (&v[SW-1:DATA_W-1] || ~|v[SW-1:DATA_W-1]) begin
            r = v;
        end else if (v[SW-1]) begin
            r = WMIN;
        end else begin
            r = WMAX;
        end
        return r[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshake and flow control
    // A stage loads when it is empty or the stage after it loads; the
    // output stage loads when empty or when the downstream takes a transfer.
    // ------------------------------------------------------------------
    logic [NST:1] adv;
    logic [NST:1] r_vld;
    logic [1:0]   r_row;
    logic         in_mat;
    logic         in_ok;

    always_comb begin
        adv[NST] = !r_vld[NST] || !i_stall;
        for (int k = NST - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign in_mat  = (i_mode == MODE_MAT);
    assign in_ok   = (i_mode == MODE_MUL) || (i_mode == MODE_ROT) || in_mat ||
                     (i_mode == MODE_CONJ) || (i_mode == MODE_NORM);
    // Hold the input while matrix rows are still being issued
    assign o_stall = !adv[1] || (i_valid && in_mat && (r_row != ROW_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_row <= ROW_0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_valid && in_ok;
                if (i_valid && in_mat) begin
                    r_row <= (r_row == ROW_LAST) ? ROW_0 : r_row + 2'd1;
                end
            end
            for (int k = 2; k <= NST; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage payloads
    // ------------------------------------------------------------------
    t_word w_in_a [4];
    t_word w_in_b [4];

    assign w_in_a[CX] = i_a_x;
    assign w_in_a[CY] = i_a_y;
    assign w_in_a[CZ] = i_a_z;
    assign w_in_a[CW] = i_a_w;
    assign w_in_b[CX] = i_b_x;
    assign w_in_b[CY] = i_b_y;
    assign w_in_b[CZ] = i_b_z;
    assign w_in_b[CW] = i_b_w;

    // stage 1: operands
    t_ctl  r_s1_ctl;
    t_word r_s1_a [4];
    t_word r_s1_b [4];
    // stage 2: first bank products
    t_ctl  r_s2_ctl;
    t_word r_s2_a [4];
    t_word r_s2_b [4];
    logic signed [PW-1:0] r_s2_p [NPROD];
    // stage 3: rounded products
    t_ctl  r_s3_ctl;
    t_word r_s3_a [4];
    t_word r_s3_b [4];
    logic signed [MW-1:0] r_s3_q [NPROD];
    // stage 4: sums, first cross product
    t_ctl  r_s4_ctl;
    t_word r_s4_a [4];
    t_word r_s4_b [3];
    t_word r_s4_res [4];
    t_word r_s4_u [3];
    // stage 5: second bank products
    t_ctl  r_s5_ctl;
    t_word r_s5_b [3];
    t_word r_s5_res [4];
    logic signed [PW-1:0] r_s5_n [NROT];
    // stage 6: rounded second bank
    t_ctl  r_s6_ctl;
    t_word r_s6_b [3];
    t_word r_s6_res [4];
    logic signed [MW-1:0] r_s6_r [NROT];
    // stage 7: second cross product saturated
    t_ctl  r_s7_ctl;
    t_word r_s7_b [3];
    t_word r_s7_res [4];
    t_word r_s7_v [3];
    logic signed [MW-1:0] r_s7_w [3];
    // stage 8: output register
    t_ctl  r_s8_ctl;
    t_word r_s8_res [4];

    // Stage 4 combinational sums
    logic signed [SW-1:0] w_e [NPROD];
    logic signed [SW-1:0] w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_wx, w_wy, w_wz;
    t_word n_s4_res [4];
    t_word n_s4_u [3];

    always_comb begin
        for (int i = 0; i < NPROD; i++) begin
            w_e[i] = SW'(r_s3_q[i]);
        end
        // doubled terms of the rotation matrix
        w_wx = w_e[0]  <<< 1;
        w_yz = w_e[2]  <<< 1;
        w_wy = w_e[4]  <<< 1;
        w_xz = w_e[6]  <<< 1;
        w_wz = w_e[8]  <<< 1;
        w_xy = w_e[10] <<< 1;
        w_xx = w_e[13] <<< 1;
        w_yy = w_e[14] <<< 1;
        w_zz = w_e[15] <<< 1;

        // A.xyz cross B.xyz
        n_s4_u[0] = sat(w_e[2]  - w_e[3]);
        n_s4_u[1] = sat(w_e[6]  - w_e[7]);
        n_s4_u[2] = sat(w_e[10] - w_e[11]);

        for (int i = 0; i < 4; i++) begin
            n_s4_res[i] = '0;
        end

        case (r_s3_ctl.mode)
            MODE_MUL: begin
                n_s4_res[0] = sat(w_e[0]  + w_e[1]  + w_e[2]  - w_e[3]);
                n_s4_res[1] = sat(w_e[4]  + w_e[5]  + w_e[6]  - w_e[7]);
                n_s4_res[2] = sat(w_e[8]  + w_e[9]  + w_e[10] - w_e[11]);
                n_s4_res[3] = sat(w_e[12] - w_e[13] - w_e[14] - w_e[15]);
            end
            MODE_MAT: begin
                case (r_s3_ctl.row)
                    ROW_0: begin
                        n_s4_res[0] = sat(ONE - (w_yy + w_zz));
                        n_s4_res[1] = sat(w_xy - w_wz);
                        n_s4_res[2] = sat(w_xz + w_wy);
                    end
                    ROW_1: begin
                        n_s4_res[0] = sat(w_xy + w_wz);
                        n_s4_res[1] = sat(ONE - (w_xx + w_zz));
                        n_s4_res[2] = sat(w_yz - w_wx);
                    end
                    default: begin
                        n_s4_res[0] = sat(w_xz - w_wy);
                        n_s4_res[1] = sat(w_yz + w_wx);
                        n_s4_res[2] = sat(ONE - (w_xx + w_yy));
                    end
                endcase
            end
            MODE_CONJ: begin
                n_s4_res[0] = sat(-SW'(r_s3_a[CX]));
                n_s4_res[1] = sat(-SW'(r_s3_a[CY]));
                n_s4_res[2] = sat(-SW'(r_s3_a[CZ]));
                n_s4_res[3] = r_s3_a[CW];
            end
            MODE_NORM: begin
                n_s4_res[0] = sat(w_e[12] + w_e[13] + w_e[14] + w_e[15]);
            end
            default: begin
                // rotation is finished in the last stage
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // stage 1: take operands; matrix and norm square A against itself
        if (adv[1]) begin
            r_s1_ctl.mode <= t_mode'(i_mode);
            r_s1_ctl.row  <= r_row;
            r_s1_ctl.last <= !in_mat || (r_row == ROW_LAST);
            for (int i = 0; i < 4; i++) begin
                r_s1_a[i] <= w_in_a[i];
                r_s1_b[i] <= (in_mat || (i_mode == MODE_NORM)) ? w_in_a[i] : w_in_b[i];
            end
        end
        // stage 2: first multiplier bank
        if (adv[2]) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_a   <= r_s1_a;
            r_s2_b   <= r_s1_b;
            for (int i = 0; i < NPROD; i++) begin
                r_s2_p[i] <= r_s1_a[PROD_A_IDX[i]] * r_s1_b[PROD_B_IDX[i]];
            end
        end
        // stage 3: round
        if (adv[3]) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_a   <= r_s2_a;
            r_s3_b   <= r_s2_b;
            for (int i = 0; i < NPROD; i++) begin
                r_s3_q[i] <= rnd(r_s2_p[i]);
            end
        end
        // stage 4: sums and saturation
        if (adv[4]) begin
            r_s4_ctl <= r_s3_ctl;
            r_s4_a   <= r_s3_a;
            for (int i = 0; i < 3; i++) begin
                r_s4_b[i] <= r_s3_b[i];
            end
            r_s4_res <= n_s4_res;
            r_s4_u   <= n_s4_u;
        end
        // stage 5: second bank, A.xyz cross u and w times u
        if (adv[5]) begin
            r_s5_ctl  <= r_s4_ctl;
            r_s5_b    <= r_s4_b;
            r_s5_res  <= r_s4_res;
            r_s5_n[0] <= r_s4_a[CY] * r_s4_u[2];
            r_s5_n[1] <= r_s4_a[CZ] * r_s4_u[1];
            r_s5_n[2] <= r_s4_a[CZ] * r_s4_u[0];
            r_s5_n[3] <= r_s4_a[CX] * r_s4_u[2];
            r_s5_n[4] <= r_s4_a[CX] * r_s4_u[1];
            r_s5_n[5] <= r_s4_a[CY] * r_s4_u[0];
            r_s5_n[6] <= r_s4_a[CW] * r_s4_u[0];
            r_s5_n[7] <= r_s4_a[CW] * r_s4_u[1];
            r_s5_n[8] <= r_s4_a[CW] * r_s4_u[2];
        end
        // stage 6: round
        if (adv[6]) begin
            r_s6_ctl <= r_s5_ctl;
            r_s6_b   <= r_s5_b;
            r_s6_res <= r_s5_res;
            for (int i = 0; i < NROT; i++) begin
                r_s6_r[i] <= rnd(r_s5_n[i]);
            end
        end
        // stage 7: saturate the second cross product
        if (adv[7]) begin
            r_s7_ctl <= r_s6_ctl;
            r_s7_b   <= r_s6_b;
            r_s7_res <= r_s6_res;
            for (int k = 0; k < 3; k++) begin
                r_s7_v[k] <= sat(SW'(r_s6_r[2*k]) - SW'(r_s6_r[2*k+1]));
                r_s7_w[k] <= r_s6_r[6+k];
            end
        end
        // stage 8: finish the rotation, hold everything else
        if (adv[8]) begin
            r_s8_ctl    <= r_s7_ctl;
            r_s8_res[3] <= r_s7_res[3];
            for (int k = 0; k < 3; k++) begin
                if (r_s7_ctl.mode == MODE_ROT) begin
                    r_s8_res[k] <= sat(SW'(r_s7_b[k]) + (SW'(r_s7_w[k]) <<< 1) +
                                       (SW'(r_s7_v[k]) <<< 1));
                end else begin
                    r_s8_res[k] <= r_s7_res[k];
                end
            end
        end
    end

    assign o_valid = r_vld[NST];
    assign o_res_0 = r_s8_res[0];
    assign o_res_1 = r_s8_res[1];
    assign o_res_2 = r_s8_res[2];
    assign o_res_3 = r_s8_res[3];
    assign o_last  = r_s8_ctl.last;

`ifndef SYNTHESIS
    // Row counter never leaves the three matrix rows
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != 2'd3)
        else $error("matrix row counter out of range");

    // A matrix transfer completes on the last row and rewinds the counter
    a_row_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_mode == MODE_MAT)) |=> (r_row == ROW_0))
        else $error("matrix row counter not rewound after transfer");

    // Only matrix rows may be a non-final result
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_s8_ctl.mode != MODE_MAT)) |-> o_last)
        else $error("single result without last");

    // Vector, matrix and norm results carry no w component
    a_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((r_s8_ctl.mode == MODE_ROT) || (r_s8_ctl.mode == MODE_MAT) ||
                     (r_s8_ctl.mode == MODE_NORM))) |-> (o_res_3 == '0))
        else $error("non-zero w on a non-quaternion result");

    // A squared norm is never negative
    a_norm_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_s8_ctl.mode == MODE_NORM)) |-> !o_res_0[DATA_W-1])
        else $error("negative squared norm");
`endif

endmodule
